// ----- src/rnorm_pkg.sv -----
// rnorm_pkg: widths, microcode types and control store of the rational normalizer
`default_nettype none
package rnorm_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int MAG_W      = DATA_WIDTH - 1;
    localparam int PC_W       = 5;
    localparam int DIV_CNT_W  = $clog2(MAG_W + 1);

    typedef logic [PC_W-1:0] rnorm_pc_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_START_BA,
        ACT_START_AB,
        ACT_WR_B_REM,
        ACT_WR_A_REM,
        ACT_SET_G,
        ACT_START_NG,
        ACT_START_DG,
        ACT_WR_N_QUO,
        ACT_WR_D_QUO,
        ACT_SET_ZERO,
        ACT_EMIT
    } rnorm_act_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_D_ZERO,
        COND_N_ZERO,
        COND_AB_DONE,
        COND_A_GT_B,
        COND_DIV_BUSY
    } rnorm_cond_t;

    // the emit step also waits in place while the output word is still held
    typedef struct packed {
        rnorm_act_t  act;
        rnorm_cond_t cond;
        rnorm_pc_t   target;
    } rnorm_ctl_t;

    typedef struct packed {
        logic in_valid;
        logic d_zero;
        logic n_zero;
        logic ab_done;
        logic a_gt_b;
        logic div_busy;
        logic out_full;
    } rnorm_flags_t;

    // program addresses
    localparam rnorm_pc_t PC_WAIT     = PC_W'(0);
    localparam rnorm_pc_t PC_LOOP     = PC_W'(3);
    localparam rnorm_pc_t PC_A_MOD_B  = PC_W'(8);
    localparam rnorm_pc_t PC_GCD_DONE = PC_W'(11);
    localparam rnorm_pc_t PC_EMIT     = PC_W'(18);
    localparam rnorm_pc_t PC_ZERO     = PC_W'(20);

    function automatic rnorm_ctl_t rnorm_rom(input rnorm_pc_t pc);
        rnorm_ctl_t w;
        w = '{act: ACT_NONE, cond: COND_ALWAYS, target: PC_WAIT};
        unique case (pc)
            5'd0:  w = '{act: ACT_LOAD,     cond: COND_NO_INPUT, target: PC_WAIT};
            5'd1:  w = '{act: ACT_NONE,     cond: COND_D_ZERO,   target: PC_ZERO};
            5'd2:  w = '{act: ACT_NONE,     cond: COND_N_ZERO,   target: PC_ZERO};
            5'd3:  w = '{act: ACT_NONE,     cond: COND_AB_DONE,  target: PC_GCD_DONE};
            5'd4:  w = '{act: ACT_NONE,     cond: COND_A_GT_B,   target: PC_A_MOD_B};
            5'd5:  w = '{act: ACT_START_BA, cond: COND_NEVER,    target: PC_WAIT};
            5'd6:  w = '{act: ACT_NONE,     cond: COND_DIV_BUSY, target: PC_W'(6)};
            5'd7:  w = '{act: ACT_WR_B_REM, cond: COND_ALWAYS,   target: PC_LOOP};
            5'd8:  w = '{act: ACT_START_AB, cond: COND_NEVER,    target: PC_WAIT};
            5'd9:  w = '{act: ACT_NONE,     cond: COND_DIV_BUSY, target: PC_W'(9)};
            5'd10: w = '{act: ACT_WR_A_REM, cond: COND_ALWAYS,   target: PC_LOOP};
            5'd11: w = '{act: ACT_SET_G,    cond: COND_NEVER,    target: PC_WAIT};
            5'd12: w = '{act: ACT_START_NG, cond: COND_NEVER,    target: PC_WAIT};
            5'd13: w = '{act: ACT_NONE,     cond: COND_DIV_BUSY, target: PC_W'(13)};
            5'd14: w = '{act: ACT_WR_N_QUO, cond: COND_NEVER,    target: PC_WAIT};
            5'd15: w = '{act: ACT_START_DG, cond: COND_NEVER,    target: PC_WAIT};
            5'd16: w = '{act: ACT_NONE,     cond: COND_DIV_BUSY, target: PC_W'(16)};
            5'd17: w = '{act: ACT_WR_D_QUO, cond: COND_NEVER,    target: PC_WAIT};
            5'd18: w = '{act: ACT_EMIT,     cond: COND_NEVER,    target: PC_WAIT};
            5'd19: w = '{act: ACT_NONE,     cond: COND_ALWAYS,   target: PC_WAIT};
            5'd20: w = '{act: ACT_SET_ZERO, cond: COND_ALWAYS,   target: PC_EMIT};
            default: w = '{act: ACT_NONE,   cond: COND_ALWAYS,   target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- src/rnorm_div.sv -----
// rnorm_div: restoring divider for magnitudes, one quotient bit per cycle
`default_nettype none
module rnorm_div
    import rnorm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [MAG_W-1:0] dividend,
    input  wire logic [MAG_W-1:0] divisor,
    output logic                  busy,
    output logic      [MAG_W-1:0] quotient,
    output logic      [MAG_W-1:0] remainder
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0]     quo_reg, quo_next;
    logic [MAG_W-1:0]     rem_reg, rem_next;
    logic [MAG_W-1:0]     dvs_reg, dvs_next;
    logic [MAG_W:0]       trial;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[MAG_W-1]} - {1'b0, dvs_reg};
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            cnt_next = DIV_CNT_W'(MAG_W);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            // no borrow means the divisor fits: keep the difference
            if (!trial[MAG_W])
            begin
                rem_next = trial[MAG_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[MAG_W-2:0], quo_reg[MAG_W-1]};
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// ----- src/rnorm_seq.sv -----
// rnorm_seq: step counter, control store lookup and conditional jumps
`default_nettype none
module rnorm_seq
    import rnorm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire rnorm_flags_t flags,
    output rnorm_ctl_t        ctl
);

    rnorm_pc_t pc_reg, pc_next;
    logic      take;
    logic      hold;

    assign ctl = rnorm_rom(pc_reg);

    always_comb
    begin
        unique case (ctl.cond)
            COND_NEVER:    take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_INPUT: take = !flags.in_valid;
            COND_D_ZERO:   take = flags.d_zero;
            COND_N_ZERO:   take = flags.n_zero;
            COND_AB_DONE:  take = flags.ab_done;
            COND_A_GT_B:   take = flags.a_gt_b;
            COND_DIV_BUSY: take = flags.div_busy;
            default:       take = 1'b0;
        endcase
    end

    // emit waits in place until the output register is free
    assign hold = (ctl.act == ACT_EMIT) && flags.out_full;

    always_comb
    begin
        if (hold)
            pc_next = pc_reg;
        else if (take)
            pc_next = ctl.target;
        else
            pc_next = pc_reg + PC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= PC_WAIT;
        else
            pc_reg <= pc_next;
    end

endmodule
`default_nettype wire

// ----- src/rational_normalizer_core.sv -----
// rational_normalizer_core: reduces a signed fraction to lowest terms
//
//   channel | direction | payload                                | handshake
//   in      | input     | numer_in, denom_in                     | in_valid / in_ready
//   out     | output    | numer_out, denom_out, bad_denominator  | out_valid / out_ready
//
// one word at a time; an accepted word runs the remainder steps of the gcd loop and then
// the two final divisions by the gcd, all on the shared one-bit-per-cycle divider
// zero numerator or zero denominator skips the gcd loop and emits 0/1
// reset clears the step counter, divider count and output valid
// a held output word stalls the emit step, and the next input word waits until it leaves
`default_nettype none
module rational_normalizer_core
    import rnorm_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [DATA_WIDTH-1:0] numer_in,
    input  wire logic signed [DATA_WIDTH-1:0] denom_in,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed      [DATA_WIDTH-1:0] numer_out,
    output logic             [MAG_W-1:0]      denom_out,
    output logic                              bad_denominator
);

    rnorm_ctl_t   ctl;
    rnorm_flags_t flags;

    logic [MAG_W-1:0] n_reg, n_next;
    logic [MAG_W-1:0] d_reg, d_next;
    logic [MAG_W-1:0] a_reg, a_next;
    logic [MAG_W-1:0] b_reg, b_next;
    logic [MAG_W-1:0] g_reg, g_next;
    logic             neg_reg, neg_next;
    logic             bad_reg, bad_next;

    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] numer_reg, numer_next;
    logic [MAG_W-1:0]      denom_reg, denom_next;
    logic                  badout_reg, badout_next;

    logic [DATA_WIDTH-1:0] n_neg_val, d_neg_val;
    logic [MAG_W-1:0]      n_mag, d_mag;
    logic [DATA_WIDTH-1:0] signed_n;

    logic             div_start;
    logic [MAG_W-1:0] div_dividend, div_divisor;
    logic             div_busy;
    logic [MAG_W-1:0] div_quo, div_rem;
    logic             out_full;
    logic             emit;

    rnorm_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl)
    );

    rnorm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // magnitudes, the most negative value saturates to all ones
    always_comb
    begin
        n_neg_val = -numer_in;
        d_neg_val = -denom_in;
        if (!numer_in[DATA_WIDTH-1])
            n_mag = numer_in[MAG_W-1:0];
        else if (n_neg_val[DATA_WIDTH-1])
            n_mag = '1;
        else
            n_mag = n_neg_val[MAG_W-1:0];
        if (!denom_in[DATA_WIDTH-1])
            d_mag = denom_in[MAG_W-1:0];
        else if (d_neg_val[DATA_WIDTH-1])
            d_mag = '1;
        else
            d_mag = d_neg_val[MAG_W-1:0];
    end

    assign out_full = out_valid_reg && !out_ready;
    assign in_ready = (ctl.act == ACT_LOAD);
    assign emit     = (ctl.act == ACT_EMIT) && !out_full;

    always_comb
    begin
        flags.in_valid = in_valid;
        flags.d_zero   = (d_reg == '0);
        flags.n_zero   = (n_reg == '0);
        flags.ab_done  = (a_reg == '0) || (b_reg == '0);
        flags.a_gt_b   = (a_reg > b_reg);
        flags.div_busy = div_busy;
        flags.out_full = out_full;
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = b_reg;
        div_divisor  = a_reg;
        case (ctl.act)
            ACT_START_BA:
            begin
                div_start    = 1'b1;
                div_dividend = b_reg;
                div_divisor  = a_reg;
            end
            ACT_START_AB:
            begin
                div_start    = 1'b1;
                div_dividend = a_reg;
                div_divisor  = b_reg;
            end
            ACT_START_NG:
            begin
                div_start    = 1'b1;
                div_dividend = n_reg;
                div_divisor  = g_reg;
            end
            ACT_START_DG:
            begin
                div_start    = 1'b1;
                div_dividend = d_reg;
                div_divisor  = g_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        n_next   = n_reg;
        d_next   = d_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        g_next   = g_reg;
        neg_next = neg_reg;
        bad_next = bad_reg;
        case (ctl.act)
            ACT_LOAD:
            begin
                if (in_valid)
                begin
                    n_next   = n_mag;
                    d_next   = d_mag;
                    a_next   = n_mag;
                    b_next   = d_mag;
                    neg_next = numer_in[DATA_WIDTH-1] ^ denom_in[DATA_WIDTH-1];
                    bad_next = (d_mag == '0);
                end
            end
            ACT_WR_B_REM: b_next = div_rem;
            ACT_WR_A_REM: a_next = div_rem;
            // one of the two is zero here
            ACT_SET_G:    g_next = a_reg | b_reg;
            ACT_WR_N_QUO: n_next = div_quo;
            ACT_WR_D_QUO: d_next = div_quo;
            ACT_SET_ZERO:
            begin
                n_next = '0;
                d_next = MAG_W'(1);
            end
            default: ;
        endcase
    end

    assign signed_n = neg_reg ? -{1'b0, n_reg} : {1'b0, n_reg};

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        numer_next     = numer_reg;
        denom_next     = denom_reg;
        badout_next    = badout_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            numer_next     = signed_n;
            denom_next     = d_reg;
            badout_next    = bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        d_reg      <= d_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        g_reg      <= g_next;
        neg_reg    <= neg_next;
        bad_reg    <= bad_next;
        numer_reg  <= numer_next;
        denom_reg  <= denom_next;
        badout_reg <= badout_next;
    end

    assign out_valid       = out_valid_reg;
    assign numer_out       = numer_reg;
    assign denom_out       = denom_reg;
    assign bad_denominator = badout_reg;

endmodule
`default_nettype wire

// ----- src/rnorm_chk.sv -----
// rnorm_chk: port-level checks of the rational normalizer and their binding
`default_nettype none
module rnorm_chk
    import rnorm_pkg::*;
(
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic signed [DATA_WIDTH-1:0] numer_out,
    input wire logic        [MAG_W-1:0]      denom_out,
    input wire logic                         bad_denominator
);

    // a held output word keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(numer_out) && $stable(denom_out)
            && $stable(bad_denominator))
        else $error("output word changed while stalled");

    // one word at a time: ready drops right after an accepted word
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready stayed high after an accepted word");

    a_bad_is_zero_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_denominator |-> numer_out == '0 && denom_out == MAG_W'(1))
        else $error("bad denominator word is not 0/1");

    a_denom_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> denom_out != '0)
        else $error("zero denominator on output");

    a_zero_numer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && numer_out == '0 |-> denom_out == MAG_W'(1))
        else $error("zero numerator not reduced to 0/1");

endmodule

bind rational_normalizer_core rnorm_chk u_rnorm_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .numer_out       (numer_out),
    .denom_out       (denom_out),
    .bad_denominator (bad_denominator)
);
`default_nettype wire
